// File: hdl/led_pattern_sequencer_assert.svh
// assertion macros shared by the checker of the led pattern sequencer
// expects signals named clk and rst_n in the scope of each use
`ifndef LED_PATTERN_SEQUENCER_ASSERT_SVH
`define LED_PATTERN_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define LPS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lps assertion failed");

// next-cycle implication
`define LPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lps assertion failed");

// delayed implication
`define LPS_ASSERT_LATER2(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> ##1 (cons)) \
    else $error("lps assertion failed");

`endif

// File: hdl/lps_pkg.sv
// types, constants and pattern rom of the led pattern sequencer
// no dependencies
`default_nettype none

package lps_pkg;

  localparam int KIND_W      = 2;
  localparam int LED_IDX_W   = 3;
  localparam int PAT_W       = 4;
  localparam int ELAPSED_W   = 16;
  localparam int WAKE_W      = 16;
  localparam int STEP_W      = 3;
  localparam int PASS_W      = 4;
  localparam int DUR_W       = 12;
  localparam int IN_DATA_W   = 24;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK    = 2'd0,
    KIND_SET     = 2'd1,
    KIND_ALL_OFF = 2'd2
  } kind_t;

  localparam logic [PAT_W-1:0]  PAT_NONE      = 4'd0;
  localparam logic [PAT_W-1:0]  PAT_OFF       = 4'd1;
  localparam logic [PAT_W-1:0]  PAT_ON        = 4'd2;
  localparam logic [PAT_W-1:0]  PATTERN_COUNT = 4'd14;
  localparam logic [PASS_W-1:0] PASS_MAX      = 4'd15;
  localparam logic [WAKE_W-1:0] WAKE_MAX      = 16'hffff;

  // input transaction payload, led_index in the lowest bits
  typedef struct packed {
    logic                 pad;
    logic [ELAPSED_W-1:0] elapsed_ms;
    logic [PAT_W-1:0]     pattern_id;
    logic [LED_IDX_W-1:0] led_index;
  } in_data_t;

  typedef struct packed {
    logic             on;
    logic             hold;
    logic [DUR_W-1:0] dur;
  } step_t;

  typedef struct packed {
    logic [STEP_W-1:0] len;
    logic [PASS_W-1:0] limit;
  } pat_info_t;

  function automatic pat_info_t pat_info(input logic [PAT_W-1:0] pid);
    pat_info_t r;
    r = '0;
    case (pid)
      4'd1, 4'd2:                          r = '{len: 3'd1, limit: 4'd0};
      4'd3, 4'd4, 4'd5, 4'd6, 4'd7:        r = '{len: 3'd2, limit: 4'd0};
      4'd8:                                r = '{len: 3'd5, limit: 4'd0};
      4'd9, 4'd10, 4'd11, 4'd12:           r = '{len: 3'd2, limit: 4'd0};
      4'd13:                               r = '{len: 3'd2, limit: 4'd8};
      default:                             r = '0;
    endcase
    return r;
  endfunction

  function automatic step_t mk_step(input logic on, input logic hold,
                                    input int dur);
    step_t r;
    r.on   = on;
    r.hold = hold;
    r.dur  = DUR_W'(dur);
    return r;
  endfunction

  function automatic step_t pat_step(input logic [PAT_W-1:0] pid,
                                     input logic [STEP_W-1:0] si);
    step_t r;
    r = '0;
    case (pid)
      4'd1:  r = mk_step(1'b0, 1'b1, 0);
      4'd2:  r = mk_step(1'b1, 1'b1, 0);
      4'd3:  r = (si == 3'd0) ? mk_step(1'b1, 1'b0, 500)  : mk_step(1'b0, 1'b0, 500);
      4'd4:  r = (si == 3'd0) ? mk_step(1'b1, 1'b0, 250)  : mk_step(1'b0, 1'b0, 250);
      4'd5:  r = (si == 3'd0) ? mk_step(1'b1, 1'b0, 125)  : mk_step(1'b0, 1'b0, 125);
      4'd6:  r = (si == 3'd0) ? mk_step(1'b1, 1'b0, 62)   : mk_step(1'b0, 1'b0, 62);
      4'd7:  r = (si == 3'd0) ? mk_step(1'b1, 1'b0, 50)   : mk_step(1'b0, 1'b0, 450);
      4'd8: begin
        case (si)
          3'd0, 3'd2: r = mk_step(1'b1, 1'b0, 125);
          3'd1, 3'd3: r = mk_step(1'b0, 1'b0, 125);
          default:    r = mk_step(1'b0, 1'b0, 1000);
        endcase
      end
      4'd9:  r = (si == 3'd0) ? mk_step(1'b1, 1'b0, 1000) : mk_step(1'b0, 1'b1, 0);
      4'd10: r = (si == 3'd0) ? mk_step(1'b1, 1'b0, 2000) : mk_step(1'b0, 1'b1, 0);
      4'd11: r = (si == 3'd0) ? mk_step(1'b1, 1'b0, 3000) : mk_step(1'b0, 1'b1, 0);
      4'd12: r = (si == 3'd0) ? mk_step(1'b0, 1'b0, 3000) : mk_step(1'b1, 1'b1, 0);
      4'd13: r = (si == 3'd0) ? mk_step(1'b1, 1'b0, 62)   : mk_step(1'b0, 1'b0, 62);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/led_pattern_sequencer.sv
// Drives NUM_CHANNELS leds from a rom of thirteen blink patterns. Every input transaction
// (tick, set pattern, all off) yields exactly one result transaction with the led levels and
// the nearest pending wake time. One transaction is taken per clock while the output side is not
// stalled; it passes through the input register and then, in a single update pass of all
// channels, into the result register.
// depends on lps_pkg
`default_nettype none

module led_pattern_sequencer #(
  parameter int NUM_CHANNELS = 5,
  parameter int TIME_BITS    = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // led_index[2:0], pattern_id[6:3], elapsed_ms[22:7], zero pad
  input  logic [lps_pkg::IN_DATA_W-1:0]         in_tdata,
  // kind[1:0]
  input  logic [lps_pkg::KIND_W-1:0]            in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // led_levels[NUM_CHANNELS-1:0], next_wake_ms[NUM_CHANNELS+15:NUM_CHANNELS], zero pad
  output logic [((NUM_CHANNELS + lps_pkg::WAKE_W + 7) / 8) * 8 - 1:0] out_tdata
);

  import lps_pkg::*;

  localparam int OUT_W = ((NUM_CHANNELS + WAKE_W + 7) / 8) * 8;
  localparam int CMP_W = (TIME_BITS > ELAPSED_W) ? TIME_BITS : ELAPSED_W;
  localparam logic [CMP_W-1:0] TIME_MAX_EXT = CMP_W'({TIME_BITS{1'b1}});
  localparam logic [CMP_W-1:0] WAKE_MAX_EXT = CMP_W'(WAKE_MAX);

  in_data_t in_data;

  logic                 ir_valid_r, ir_valid_nxt;
  kind_t                ir_kind_r;
  logic [LED_IDX_W-1:0] ir_led_r;
  logic [PAT_W-1:0]     ir_pat_r;
  logic [ELAPSED_W-1:0] ir_elapsed_r;
  logic                 adv;

  logic [PAT_W-1:0]     chan_pattern_r [NUM_CHANNELS];
  logic [PAT_W-1:0]     chan_pattern_nxt [NUM_CHANNELS];
  logic [STEP_W-1:0]    step_index_r [NUM_CHANNELS];
  logic [STEP_W-1:0]    step_index_nxt [NUM_CHANNELS];
  logic [PASS_W-1:0]    pass_count_r [NUM_CHANNELS];
  logic [PASS_W-1:0]    pass_count_nxt [NUM_CHANNELS];
  logic [TIME_BITS-1:0] wait_ms_r [NUM_CHANNELS];
  logic [TIME_BITS-1:0] wait_ms_nxt [NUM_CHANNELS];
  logic                 parked_r [NUM_CHANNELS];
  logic                 parked_nxt [NUM_CHANNELS];
  logic                 lit_r [NUM_CHANNELS];
  logic                 lit_nxt [NUM_CHANNELS];
  logic [WAKE_W-1:0]    wake_cand [NUM_CHANNELS];

  logic [NUM_CHANNELS-1:0] levels;
  logic [WAKE_W-1:0]       wake;

  logic                    out_valid_r;
  logic [NUM_CHANNELS-1:0] out_levels_r;
  logic [WAKE_W-1:0]       out_wake_r;

  // input register
  assign in_data   = in_data_t'(in_tdata);
  assign adv       = ir_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !ir_valid_r || adv;

  always_comb begin
    ir_valid_nxt = ir_valid_r;
    if (in_tvalid && in_tready) begin
      ir_valid_nxt = 1'b1;
    end else if (adv) begin
      ir_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ir_valid_r <= 1'b0;
    end else begin
      ir_valid_r <= ir_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      ir_kind_r    <= kind_t'(in_tuser);
      ir_led_r     <= in_data.led_index;
      ir_pat_r     <= in_data.pattern_id;
      ir_elapsed_r <= in_data.elapsed_ms;
    end
  end

  // per-channel update
  for (genvar ch = 0; ch < NUM_CHANNELS; ch++) begin : g_chan
    pat_info_t             info;
    step_t                 stp;
    logic [STEP_W-1:0]     si_eff;
    logic [STEP_W-1:0]     si_inc;
    logic                  valid_pat;
    logic [CMP_W-1:0]      wait_ext;
    logic [CMP_W-1:0]      elap_ext;
    logic [CMP_W-1:0]      dur_ext;
    logic [CMP_W-1:0]      wait_nxt_ext;
    logic [TIME_BITS-1:0]  dur_sat;

    assign info      = pat_info(chan_pattern_r[ch]);
    assign si_eff    = (step_index_r[ch] >= info.len) ? '0 : step_index_r[ch];
    assign si_inc    = si_eff + 3'd1;
    assign stp       = pat_step(chan_pattern_r[ch], si_eff);
    assign valid_pat = (chan_pattern_r[ch] != PAT_NONE) && (chan_pattern_r[ch] < PATTERN_COUNT);
    assign wait_ext  = CMP_W'(wait_ms_r[ch]);
    assign elap_ext  = CMP_W'(ir_elapsed_r);
    assign dur_ext   = CMP_W'(stp.dur);
    assign dur_sat   = (dur_ext > TIME_MAX_EXT) ? {TIME_BITS{1'b1}} : dur_ext[TIME_BITS-1:0];

    always_comb begin
      chan_pattern_nxt[ch] = chan_pattern_r[ch];
      step_index_nxt[ch]   = step_index_r[ch];
      pass_count_nxt[ch]   = pass_count_r[ch];
      wait_ms_nxt[ch]      = wait_ms_r[ch];
      parked_nxt[ch]       = parked_r[ch];
      lit_nxt[ch]          = lit_r[ch];
      if (adv) begin
        unique case (ir_kind_r)
          KIND_TICK: begin
            if (!parked_r[ch]) begin
              if (wait_ext <= elap_ext) begin
                if (!valid_pat) begin
                  parked_nxt[ch] = 1'b1;
                end else if (info.limit != '0 && pass_count_r[ch] >= info.limit) begin
                  lit_nxt[ch]    = 1'b0;
                  parked_nxt[ch] = 1'b1;
                end else begin
                  lit_nxt[ch] = stp.on;
                  if (stp.hold) begin
                    parked_nxt[ch] = 1'b1;
                  end else begin
                    wait_ms_nxt[ch] = dur_sat;
                  end
                  if (si_inc >= info.len) begin
                    step_index_nxt[ch] = '0;
                    if (pass_count_r[ch] != PASS_MAX) begin
                      pass_count_nxt[ch] = pass_count_r[ch] + 4'd1;
                    end
                  end else begin
                    step_index_nxt[ch] = si_inc;
                  end
                end
              end else begin
                wait_ms_nxt[ch] = TIME_BITS'(wait_ext - elap_ext);
              end
            end
          end
          KIND_SET: begin
            if (int'(ir_led_r) == ch) begin
              chan_pattern_nxt[ch] = ir_pat_r;
              step_index_nxt[ch]   = '0;
              pass_count_nxt[ch]   = '0;
              wait_ms_nxt[ch]      = '0;
              parked_nxt[ch]       = 1'b0;
            end
          end
          KIND_ALL_OFF: begin
            chan_pattern_nxt[ch] = PAT_OFF;
            step_index_nxt[ch]   = '0;
            pass_count_nxt[ch]   = '0;
            wait_ms_nxt[ch]      = '0;
            parked_nxt[ch]       = 1'b0;
          end
          default: begin
          end
        endcase
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        chan_pattern_r[ch] <= (ch == 2) ? PAT_ON : PAT_OFF;
        step_index_r[ch]   <= '0;
        pass_count_r[ch]   <= '0;
        wait_ms_r[ch]      <= '0;
        parked_r[ch]       <= 1'b0;
        lit_r[ch]          <= 1'b0;
      end else begin
        chan_pattern_r[ch] <= chan_pattern_nxt[ch];
        step_index_r[ch]   <= step_index_nxt[ch];
        pass_count_r[ch]   <= pass_count_nxt[ch];
        wait_ms_r[ch]      <= wait_ms_nxt[ch];
        parked_r[ch]       <= parked_nxt[ch];
        lit_r[ch]          <= lit_nxt[ch];
      end
    end

    assign wait_nxt_ext  = CMP_W'(wait_ms_nxt[ch]);
    assign levels[ch]    = lit_nxt[ch];
    assign wake_cand[ch] = parked_nxt[ch] ? WAKE_MAX :
                           (wait_nxt_ext > WAKE_MAX_EXT) ? WAKE_MAX :
                           wait_nxt_ext[WAKE_W-1:0];
  end

  // nearest wake time over channels
  always_comb begin
    wake = WAKE_MAX;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (wake_cand[i] < wake) begin
        wake = wake_cand[i];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_levels_r <= levels;
      out_wake_r   <= wake;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_wake_r, out_levels_r});

endmodule

`default_nettype wire

// File: hdl/lps_checker.sv
// port-level checker of the led pattern sequencer, bound to the top level
// depends on led_pattern_sequencer_assert.svh
`default_nettype none

`include "led_pattern_sequencer_assert.svh"

module lps_checker #(
  parameter int DATA_W = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [DATA_W-1:0] out_tdata
);

  // stalled result holds
  `LPS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // input side never stalls while the result side is empty
  `LPS_ASSERT_SAME(a_ready_when_empty, !out_tvalid, in_tready)

  // each accepted transaction finds out_tvalid set once it has passed the input and result registers
  `LPS_ASSERT_LATER2(a_result_latency, in_tvalid && in_tready, out_tvalid)

  // a second transaction behind a stalled result fills the input register
  `LPS_ASSERT_NEXT(a_backpressure, in_tvalid && in_tready && out_tvalid && !out_tready,
                   out_tready || !in_tready)

endmodule

bind led_pattern_sequencer lps_checker #(.DATA_W(OUT_W)) u_lps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
